/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file mcs_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is masked while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/mcs_pkg.sv */
// ----------------------------------------------------------------------------
// mcs_pkg
// Shared types, codes and reset constants for the molding cycle sequencer.
// ----------------------------------------------------------------------------
package mcs_pkg;

  // Field widths
  localparam int TEMP_W   = 11;
  localparam int DUTY_W   = 8;
  localparam int HOLD_W   = 16;
  localparam int BLINK_W  = 10;
  localparam int MELT_W   = 22;
  localparam int ACTION_W = 2;
  localparam int PHASE_W  = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Default phase timer width
  localparam int MCS_TIMER_BITS = 23;

  // Reset values
  localparam logic [DUTY_W-1:0]  HEATER_DUTY_RST   = DUTY_W'(210);
  localparam logic [HOLD_W-1:0]  INSERT_HOLD_RST   = HOLD_W'(10000);
  localparam logic [HOLD_W-1:0]  INJECT_HOLD_RST   = HOLD_W'(60000);
  localparam logic [BLINK_W-1:0] LED_HALF_RST      = BLINK_W'(500);
  localparam logic [TEMP_W-1:0]  WARM_THRESH_RST   = TEMP_W'(40);
  localparam logic [TEMP_W-1:0]  NOZZLE_SP_RST     = TEMP_W'(220);
  localparam logic [TEMP_W-1:0]  BARREL_SP_RST     = TEMP_W'(210);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEATER_DUTY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INSERT_HOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INJECT_HOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LED_HALF    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WARM_THRESH = 3'd4;

  typedef enum logic [PHASE_W-1:0] {
    PH_STANDBY = 3'd0,
    PH_HEAT    = 3'd1,
    PH_INSERT  = 3'd2,
    PH_MELT    = 3'd3,
    PH_INJECT  = 3'd4
  } phase_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK   = 2'd0,
    ACT_START  = 2'd1,
    ACT_CANCEL = 2'd2,
    ACT_HEAT   = 2'd3
  } action_t;

  typedef struct packed {
    logic [DUTY_W-1:0]  heater_duty;
    logic [HOLD_W-1:0]  insert_hold;
    logic [HOLD_W-1:0]  inject_hold;
    logic [BLINK_W-1:0] led_half;
    logic [TEMP_W-1:0]  warm_thresh;
  } cfg_regs_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [TEMP_W-1:0]   nozzle_reading;
    logic [TEMP_W-1:0]   barrel_reading;
    logic [TEMP_W-1:0]   nozzle_target;
    logic [TEMP_W-1:0]   barrel_target;
    logic [MELT_W-1:0]   melt_ticks;
  } item_t;

  typedef struct packed {
    phase_t            phase;
    logic [DUTY_W-1:0] nozzle_drive;
    logic [DUTY_W-1:0] barrel_drive;
    logic              door_open;
    logic              piston_push;
    logic              led_on;
    logic              heating_active;
  } result_t;

endpackage

/* rtl/molding_cycle_sequencer_core.sv */
// An accepted item is held in the input register; its result is registered in the result register.
// Throughput: one item per cycle; the input register and the result
// register are separate, so a new item is taken while a result waits.
// Input stalls only when both registers are full and the result is stalled.
// Reset (rst, synchronous): standby phase, actuators off, no results pending,
// configuration and setpoints back to their defaults.
// ----------------------------------------------------------------------------
// molding_cycle_sequencer_core
// Heated injection cycle sequencer: input register, single-pass sequencer
// logic, result register and configuration registers.
// ----------------------------------------------------------------------------
module molding_cycle_sequencer_core
  import mcs_pkg::*;
#(
  parameter int TIMER_BITS = MCS_TIMER_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  // Item channel
  input  logic                  item_valid,
  output logic                  item_stall,
  input  logic [ACTION_W-1:0]   action,
  input  logic [TEMP_W-1:0]     nozzle_reading,
  input  logic [TEMP_W-1:0]     barrel_reading,
  input  logic [TEMP_W-1:0]     nozzle_target,
  input  logic [TEMP_W-1:0]     barrel_target,
  input  logic [MELT_W-1:0]     melt_ticks,
  // Result channel
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic [PHASE_W-1:0]    phase,
  output logic [DUTY_W-1:0]     nozzle_drive,
  output logic [DUTY_W-1:0]     barrel_drive,
  output logic                  door_open,
  output logic                  piston_push,
  output logic                  led_on,
  output logic                  heating_active,
  // Configuration channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_regs_t cfg;
  item_t     item_reg;
  logic      item_reg_valid;
  logic      item_reg_valid_next;
  logic      result_valid_next;
  result_t   result_reg;
  result_t   result_next;
  logic      item_accept;
  logic      advance;

  mcs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Handshake: move forward when the result register is free or draining
  assign advance     = item_reg_valid & (~result_valid | ~result_stall);
  assign item_stall  = item_reg_valid & result_valid & result_stall;
  assign item_accept = item_valid & ~item_stall;

  assign item_reg_valid_next = item_accept | (item_reg_valid & ~advance);
  assign result_valid_next   = advance | (result_valid & result_stall);

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_reg_valid <= 1'b0;
    end else begin
      item_reg_valid <= item_reg_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (item_accept) begin
      item_reg.action         <= action;
      item_reg.nozzle_reading <= nozzle_reading;
      item_reg.barrel_reading <= barrel_reading;
      item_reg.nozzle_target  <= nozzle_target;
      item_reg.barrel_target  <= barrel_target;
      item_reg.melt_ticks     <= melt_ticks;
    end
  end

  mcs_sequencer #(
    .TIMER_BITS (TIMER_BITS)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .item        (item_reg),
    .cfg         (cfg),
    .result_next (result_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_reg <= result_next;
    end
  end

  assign phase          = result_reg.phase;
  assign nozzle_drive   = result_reg.nozzle_drive;
  assign barrel_drive   = result_reg.barrel_drive;
  assign door_open      = result_reg.door_open;
  assign piston_push    = result_reg.piston_push;
  assign led_on         = result_reg.led_on;
  assign heating_active = result_reg.heating_active;

endmodule

/* rtl/mcs_cfg_regs.sv */
// ----------------------------------------------------------------------------
// mcs_cfg_regs
// Configuration register file, written by index over a valid/ready channel.
// ----------------------------------------------------------------------------
module mcs_cfg_regs
  import mcs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_regs_t             cfg
);

  logic wr_en;

  // Always take writes
  assign cfg_ready = 1'b1;
  assign wr_en     = cfg_valid & cfg_ready;

  // Update the addressed register, drop unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.heater_duty <= HEATER_DUTY_RST;
      cfg.insert_hold <= INSERT_HOLD_RST;
      cfg.inject_hold <= INJECT_HOLD_RST;
      cfg.led_half    <= LED_HALF_RST;
      cfg.warm_thresh <= WARM_THRESH_RST;
    end else if (wr_en) begin
      case (cfg_index)
        CFG_HEATER_DUTY: cfg.heater_duty <= cfg_data[DUTY_W-1:0];
        CFG_INSERT_HOLD: cfg.insert_hold <= cfg_data[HOLD_W-1:0];
        CFG_INJECT_HOLD: cfg.inject_hold <= cfg_data[HOLD_W-1:0];
        CFG_LED_HALF:    cfg.led_half    <= cfg_data[BLINK_W-1:0];
        CFG_WARM_THRESH: cfg.warm_thresh <= cfg_data[TEMP_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/mcs_sequencer.sv */
// ----------------------------------------------------------------------------
// mcs_sequencer
// Phase state machine, phase and blink timers, heater and lamp logic.
// Produces the result for the item in the input register and commits the
// new state when that item moves to the output register.
// ----------------------------------------------------------------------------
module mcs_sequencer
  import mcs_pkg::*;
#(
  parameter int TIMER_BITS = MCS_TIMER_BITS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      advance,
  input  item_t     item,
  input  cfg_regs_t cfg,
  output result_t   result_next
);

  localparam int CMP_W = (TIMER_BITS > MELT_W) ? TIMER_BITS : MELT_W;

  // State registers
  phase_t                phase;
  logic [TIMER_BITS-1:0] phase_elapsed;
  logic [BLINK_W-1:0]    blink_elapsed;
  logic                  heat_enable;
  logic                  door_flag;
  logic                  piston_flag;
  logic                  lamp_flag;
  logic [TEMP_W-1:0]     nozzle_setpoint;
  logic [TEMP_W-1:0]     barrel_setpoint;
  logic [MELT_W-1:0]     melt_limit;

  phase_t                phase_next;
  logic [TIMER_BITS-1:0] phase_elapsed_next;
  logic [BLINK_W-1:0]    blink_elapsed_next;
  logic                  heat_enable_next;
  logic                  door_flag_next;
  logic                  piston_flag_next;
  logic                  lamp_flag_next;
  logic [TEMP_W-1:0]     nozzle_setpoint_next;
  logic [TEMP_W-1:0]     barrel_setpoint_next;
  logic [MELT_W-1:0]     melt_limit_next;

  action_t               act;
  logic                  heat_pre;
  logic [MELT_W-1:0]     limit_sel;
  logic                  timer_done;
  logic [TIMER_BITS-1:0] elapsed_inc;
  logic                  nozzle_low;
  logic                  barrel_low;
  logic [DUTY_W-1:0]     nozzle_drive;
  logic [DUTY_W-1:0]     barrel_drive;

  assign act = action_t'(item.action);

  // Pick the hold of the current timed phase
  always_comb begin
    case (phase)
      PH_INSERT: limit_sel = MELT_W'(cfg.insert_hold);
      PH_INJECT: limit_sel = MELT_W'(cfg.inject_hold);
      default:   limit_sel = melt_limit;
    endcase
  end

  // Phase timer: done once the hold is reached, otherwise count and saturate
  assign timer_done  = CMP_W'(phase_elapsed) >= CMP_W'(limit_sel);
  assign elapsed_inc = (phase_elapsed != {TIMER_BITS{1'b1}}) ?
                       phase_elapsed + 1'b1 : phase_elapsed;

  // Next state: phase transitions, timers, actuators and setpoints
  always_comb begin
    phase_next           = phase;
    phase_elapsed_next   = phase_elapsed;
    heat_pre             = heat_enable;
    door_flag_next       = door_flag;
    piston_flag_next     = piston_flag;
    nozzle_setpoint_next = nozzle_setpoint;
    barrel_setpoint_next = barrel_setpoint;
    melt_limit_next      = melt_limit;
    case (act)
      ACT_TICK: begin
        case (phase)
          PH_HEAT: begin
            heat_pre = 1'b1;
            if (item.nozzle_reading >= nozzle_setpoint &&
                item.barrel_reading >= barrel_setpoint) begin
              phase_next         = PH_INSERT;
              phase_elapsed_next = '0;
              door_flag_next     = 1'b1;
            end
          end
          PH_INSERT: begin
            door_flag_next = 1'b1;
            if (timer_done) begin
              phase_next         = PH_MELT;
              phase_elapsed_next = '0;
              door_flag_next     = 1'b0;
            end else begin
              phase_elapsed_next = elapsed_inc;
            end
          end
          PH_MELT: begin
            if (timer_done) begin
              phase_next         = PH_INJECT;
              phase_elapsed_next = '0;
              piston_flag_next   = 1'b1;
            end else begin
              phase_elapsed_next = elapsed_inc;
            end
          end
          PH_INJECT: begin
            piston_flag_next = 1'b1;
            if (timer_done) begin
              phase_next         = PH_STANDBY;
              phase_elapsed_next = '0;
              piston_flag_next   = 1'b0;
              heat_pre           = 1'b0;
            end else begin
              phase_elapsed_next = elapsed_inc;
            end
          end
          default: begin
            phase_next         = PH_STANDBY;
            phase_elapsed_next = '0;
          end
        endcase
      end
      ACT_START: begin
        if (phase == PH_STANDBY) begin
          nozzle_setpoint_next = item.nozzle_target;
          barrel_setpoint_next = item.barrel_target;
          melt_limit_next      = item.melt_ticks;
          heat_pre             = 1'b1;
          phase_next           = PH_HEAT;
          phase_elapsed_next   = '0;
          door_flag_next       = 1'b0;
          piston_flag_next     = 1'b0;
        end
      end
      ACT_CANCEL: begin
        phase_next         = PH_STANDBY;
        phase_elapsed_next = '0;
        door_flag_next     = 1'b0;
        piston_flag_next   = 1'b0;
      end
      ACT_HEAT: begin
        if (phase == PH_STANDBY) begin
          nozzle_setpoint_next = item.nozzle_target;
          barrel_setpoint_next = item.barrel_target;
          heat_pre             = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Outputs: bang-bang heater, standby auto-off, lamp and blink timer
  always_comb begin
    nozzle_low         = item.nozzle_reading < nozzle_setpoint_next;
    barrel_low         = item.barrel_reading < barrel_setpoint_next;
    nozzle_drive       = '0;
    barrel_drive       = '0;
    heat_enable_next   = heat_pre;
    blink_elapsed_next = blink_elapsed;
    lamp_flag_next     = lamp_flag;
    if (heat_pre) begin
      if (nozzle_low) begin
        nozzle_drive = cfg.heater_duty;
      end
      if (barrel_low) begin
        barrel_drive = cfg.heater_duty;
      end
      if ((!nozzle_low || !barrel_low) && phase_next == PH_STANDBY) begin
        heat_enable_next = 1'b0;
      end
    end
    if (phase_next == PH_STANDBY) begin
      blink_elapsed_next = '0;
      lamp_flag_next     = (item.nozzle_reading > cfg.warm_thresh) ||
                           (item.barrel_reading > cfg.warm_thresh);
    end else if (act == ACT_TICK) begin
      if (blink_elapsed >= cfg.led_half) begin
        lamp_flag_next     = ~lamp_flag;
        blink_elapsed_next = '0;
      end else begin
        blink_elapsed_next = blink_elapsed + 1'b1;
      end
    end
  end

  // Assemble the result of this item
  always_comb begin
    result_next.phase          = phase_next;
    result_next.nozzle_drive   = nozzle_drive;
    result_next.barrel_drive   = barrel_drive;
    result_next.door_open      = door_flag_next;
    result_next.piston_push    = piston_flag_next;
    result_next.led_on         = lamp_flag_next;
    result_next.heating_active = heat_enable_next;
  end

  // Commit state when the item leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_STANDBY;
      phase_elapsed   <= '0;
      blink_elapsed   <= '0;
      heat_enable     <= 1'b0;
      door_flag       <= 1'b0;
      piston_flag     <= 1'b0;
      lamp_flag       <= 1'b0;
      nozzle_setpoint <= NOZZLE_SP_RST;
      barrel_setpoint <= BARREL_SP_RST;
      melt_limit      <= '0;
    end else if (advance) begin
      phase           <= phase_next;
      phase_elapsed   <= phase_elapsed_next;
      blink_elapsed   <= blink_elapsed_next;
      heat_enable     <= heat_enable_next;
      door_flag       <= door_flag_next;
      piston_flag     <= piston_flag_next;
      lamp_flag       <= lamp_flag_next;
      nozzle_setpoint <= nozzle_setpoint_next;
      barrel_setpoint <= barrel_setpoint_next;
      melt_limit      <= melt_limit_next;
    end
  end

endmodule

/* rtl/mcs_checker.sv */
// ----------------------------------------------------------------------------
// mcs_checker
// Port-level checks on the molding cycle sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mcs_checker
  import mcs_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               result_valid,
  input logic               result_stall,
  input logic [PHASE_W-1:0] phase,
  input logic               door_open,
  input logic               piston_push,
  input logic               heating_active
);

  // No result survives reset
  `ASSERT_ALWAYS(a_reset_clears, clk, rst |=> !result_valid, "result valid after reset")

  // Hold a stalled result
  `ASSERT_CLK(a_stall_holds, clk, rst, result_valid && result_stall |=> result_valid, "stalled result dropped")

  // Door opens only in insert, piston drives only in inject
  `ASSERT_CLK(a_door_phase, clk, rst, result_valid && door_open |-> phase == PH_INSERT, "door open outside insert")
  `ASSERT_CLK(a_piston_phase, clk, rst, result_valid && piston_push |-> phase == PH_INJECT, "piston outside inject")

  // A running cycle keeps its heaters enabled
  `ASSERT_CLK(a_heat_running, clk, rst, result_valid && phase != PH_STANDBY |-> heating_active, "heat off in cycle")

endmodule

bind molding_cycle_sequencer_core mcs_checker u_mcs_checker (
  .clk            (clk),
  .rst            (rst),
  .result_valid   (result_valid),
  .result_stall   (result_stall),
  .phase          (phase),
  .door_open      (door_open),
  .piston_push    (piston_push),
  .heating_active (heating_active)
);

/* bench/mcs_result_checker.sv */
// ----------------------------------------------------------------------------
// mcs_result_checker
// Watches the item, result and configuration channels of the molding cycle
// sequencer. It keeps its own copy of the sequencer state and registers,
// works out the result of every accepted item, and compares each accepted
// result with the oldest outstanding one.
// ----------------------------------------------------------------------------
module mcs_result_checker
  import mcs_pkg::*;
#(
  parameter int TIMER_BITS = MCS_TIMER_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  input  logic                  item_stall,
  input  logic [ACTION_W-1:0]   action,
  input  logic [TEMP_W-1:0]     nozzle_reading,
  input  logic [TEMP_W-1:0]     barrel_reading,
  input  logic [TEMP_W-1:0]     nozzle_target,
  input  logic [TEMP_W-1:0]     barrel_target,
  input  logic [MELT_W-1:0]     melt_ticks,
  input  logic                  result_valid,
  input  logic                  result_stall,
  input  logic [PHASE_W-1:0]    phase,
  input  logic [DUTY_W-1:0]     nozzle_drive,
  input  logic [DUTY_W-1:0]     barrel_drive,
  input  logic                  door_open,
  input  logic                  piston_push,
  input  logic                  led_on,
  input  logic                  heating_active,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;
  localparam logic [TIMER_BITS-1:0] TIMER_TOP = '1;

  // Register copy
  logic [DUTY_W-1:0]     duty;
  logic [HOLD_W-1:0]     insert_hold;
  logic [HOLD_W-1:0]     inject_hold;
  logic [BLINK_W-1:0]    blink_half;
  logic [TEMP_W-1:0]     warm_level;

  // Sequencer state copy
  phase_t                cur_phase;
  logic [TIMER_BITS-1:0] phase_ticks;
  logic [BLINK_W-1:0]    blink_ticks;
  logic                  heat_on;
  logic                  door;
  logic                  piston;
  logic                  lamp;
  logic [TEMP_W-1:0]     nozzle_sp;
  logic [TEMP_W-1:0]     barrel_sp;
  logic [MELT_W-1:0]     melt_limit;

  result_t               due_results[$];
  item_t                 taken;
  result_t               seen;
  result_t               want;

  function automatic void restore_defaults();
    duty        = HEATER_DUTY_RST;
    insert_hold = INSERT_HOLD_RST;
    inject_hold = INJECT_HOLD_RST;
    blink_half  = LED_HALF_RST;
    warm_level  = WARM_THRESH_RST;
    cur_phase   = PH_STANDBY;
    phase_ticks = '0;
    blink_ticks = '0;
    heat_on     = 1'b0;
    door        = 1'b0;
    piston      = 1'b0;
    lamp        = 1'b0;
    nozzle_sp   = NOZZLE_SP_RST;
    barrel_sp   = BARREL_SP_RST;
    melt_limit  = '0;
  endfunction

  function automatic void write_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_HEATER_DUTY: duty        = data[DUTY_W-1:0];
      CFG_INSERT_HOLD: insert_hold = data[HOLD_W-1:0];
      CFG_INJECT_HOLD: inject_hold = data[HOLD_W-1:0];
      CFG_LED_HALF:    blink_half  = data[BLINK_W-1:0];
      CFG_WARM_THRESH: warm_level  = data[TEMP_W-1:0];
      default: ;
    endcase
  endfunction

  // True once the phase has lasted its hold; otherwise count one tick (saturating)
  function automatic bit hold_elapsed(input logic [31:0] hold);
    if (32'(phase_ticks) >= hold) return 1'b1;
    if (phase_ticks != TIMER_TOP) phase_ticks++;
    return 1'b0;
  endfunction

  // Advance the sequencer copy by one transaction and form its result
  function automatic result_t step_sequencer(input item_t it);
    result_t           r;
    logic              reached;
    logic [DUTY_W-1:0] nz_drive;
    logic [DUTY_W-1:0] br_drive;
    nz_drive = '0;
    br_drive = '0;
    case (action_t'(it.action))
      ACT_TICK: begin
        case (cur_phase)
          PH_HEAT: begin
            heat_on = 1'b1;
            if (it.nozzle_reading >= nozzle_sp && it.barrel_reading >= barrel_sp) begin
              cur_phase   = PH_INSERT;
              phase_ticks = '0;
              door        = 1'b1;
            end
          end
          PH_INSERT: begin
            door = 1'b1;
            if (hold_elapsed(32'(insert_hold))) begin
              cur_phase   = PH_MELT;
              phase_ticks = '0;
              door        = 1'b0;
            end
          end
          PH_MELT: begin
            if (hold_elapsed(32'(melt_limit))) begin
              cur_phase   = PH_INJECT;
              phase_ticks = '0;
              piston      = 1'b1;
            end
          end
          PH_INJECT: begin
            piston = 1'b1;
            if (hold_elapsed(32'(inject_hold))) begin
              cur_phase   = PH_STANDBY;
              phase_ticks = '0;
              piston      = 1'b0;
              heat_on     = 1'b0;
            end
          end
          default: begin
            cur_phase   = PH_STANDBY;
            phase_ticks = '0;
          end
        endcase
      end
      ACT_START: begin
        if (cur_phase == PH_STANDBY) begin
          nozzle_sp   = it.nozzle_target;
          barrel_sp   = it.barrel_target;
          melt_limit  = it.melt_ticks;
          heat_on     = 1'b1;
          cur_phase   = PH_HEAT;
          phase_ticks = '0;
          blink_ticks = '0;
          door        = 1'b0;
          piston      = 1'b0;
        end
      end
      ACT_CANCEL: begin
        cur_phase   = PH_STANDBY;
        phase_ticks = '0;
        door        = 1'b0;
        piston      = 1'b0;
      end
      default: begin
        if (cur_phase == PH_STANDBY) begin
          nozzle_sp = it.nozzle_target;
          barrel_sp = it.barrel_target;
          heat_on   = 1'b1;
        end
      end
    endcase

    // Bang-bang heaters; in standby, drop the enable once a channel is hot
    if (heat_on) begin
      reached = 1'b0;
      if (it.nozzle_reading < nozzle_sp) nz_drive = duty; else reached = 1'b1;
      if (it.barrel_reading < barrel_sp) br_drive = duty; else reached = 1'b1;
      if (reached && cur_phase == PH_STANDBY) heat_on = 1'b0;
    end

    // Warm warning in standby, blink on ticks while running
    if (cur_phase == PH_STANDBY) begin
      blink_ticks = '0;
      lamp = (it.nozzle_reading > warm_level) || (it.barrel_reading > warm_level);
    end else if (action_t'(it.action) == ACT_TICK) begin
      if (blink_ticks >= blink_half) begin
        lamp        = ~lamp;
        blink_ticks = '0;
      end else begin
        blink_ticks++;
      end
    end

    r.phase          = cur_phase;
    r.nozzle_drive   = nz_drive;
    r.barrel_drive   = br_drive;
    r.door_open      = door;
    r.piston_push    = piston;
    r.led_on         = lamp;
    r.heating_active = heat_on;
    return r;
  endfunction

  function automatic void note_fault(input string what, input result_t exp_r,
                                     input result_t got_r);
    if (mismatches < REPORT_LIMIT)
      $display("%0t %s: expected ph=%0d nd=%0d bd=%0d door=%b pist=%b led=%b heat=%b",
               $time, what, exp_r.phase, exp_r.nozzle_drive, exp_r.barrel_drive,
               exp_r.door_open, exp_r.piston_push, exp_r.led_on, exp_r.heating_active,
               "\n    actual ph=%0d nd=%0d bd=%0d door=%b pist=%b led=%b heat=%b",
               got_r.phase, got_r.nozzle_drive, got_r.barrel_drive,
               got_r.door_open, got_r.piston_push, got_r.led_on, got_r.heating_active);
    mismatches++;
  endfunction

  // Retire the oldest expectation before queuing the newest one
  always @(posedge clk) begin
    if (rst) begin
      restore_defaults();
      due_results.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);

      if (result_valid && !result_stall) begin
        seen.phase          = phase_t'(phase);
        seen.nozzle_drive   = nozzle_drive;
        seen.barrel_drive   = barrel_drive;
        seen.door_open      = door_open;
        seen.piston_push    = piston_push;
        seen.led_on         = led_on;
        seen.heating_active = heating_active;
        if (due_results.size() == 0) begin
          note_fault("result with nothing outstanding", seen, seen);
        end else begin
          want = due_results.pop_front();
          if (seen !== want) note_fault("result mismatch", want, seen);
        end
      end

      if (item_valid && !item_stall) begin
        taken.action         = action;
        taken.nozzle_reading = nozzle_reading;
        taken.barrel_reading = barrel_reading;
        taken.nozzle_target  = nozzle_target;
        taken.barrel_target  = barrel_target;
        taken.melt_ticks     = melt_ticks;
        due_results.push_back(step_sequencer(taken));
      end
    end
    outstanding = due_results.size();
  end

endmodule

/* bench/tb_molding_cycle_sequencer_core.sv */
// ----------------------------------------------------------------------------
// tb_molding_cycle_sequencer_core
// Drives the molding cycle sequencer with a directed opening (heater edges,
// warm-threshold boundary, ignored starts, cancel in standby and insert, a complete
// zero-hold cycle) followed by random molding cycles, manual heat requests
// and stray commands under several register settings, with random gaps and
// result back-pressure. A checker module beside the block does the scoring.
// ----------------------------------------------------------------------------
module tb_molding_cycle_sequencer_core;
  timeunit 1ns;
  timeprecision 1ps;
  import mcs_pkg::*;

  localparam int          HALF_PERIOD    = 5;
  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int          SETTING_ROUNDS = 7;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  item_valid = 1'b0;
  logic                  item_stall;
  logic [ACTION_W-1:0]   action = ACT_TICK;
  logic [TEMP_W-1:0]     nozzle_reading = '0;
  logic [TEMP_W-1:0]     barrel_reading = '0;
  logic [TEMP_W-1:0]     nozzle_target = '0;
  logic [TEMP_W-1:0]     barrel_target = '0;
  logic [MELT_W-1:0]     melt_ticks = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic [PHASE_W-1:0]    phase;
  logic [DUTY_W-1:0]     nozzle_drive;
  logic [DUTY_W-1:0]     barrel_drive;
  logic                  door_open;
  logic                  piston_push;
  logic                  led_on;
  logic                  heating_active;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_HEATER_DUTY;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int                    mismatches;
  int                    outstanding;
  int unsigned           cycle_count = 0;
  int unsigned           items_sent = 0;
  int unsigned           round_base;
  int unsigned           round_quota;
  int unsigned           cur_insert = INSERT_HOLD_RST;
  int unsigned           cur_inject = INJECT_HOLD_RST;
  bit                    tx_burst = 1'b0;
  bit                    rx_burst = 1'b0;
  logic                  rx_took = 1'b0;
  int unsigned           rx_wait = 0;

  always #(HALF_PERIOD) clk = ~clk;

  molding_cycle_sequencer_core dut (.*);

  mcs_result_checker checker_i (.*);

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result back-pressure: hold stall for a random count after each transaction
  always @(posedge clk) rx_took <= result_valid && !result_stall;

  always @(negedge clk) begin
    if (rx_took) begin
      if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
      rx_wait = rx_burst ? 0 : $urandom_range(0, 19);
    end
    if (rx_wait != 0) begin
      result_stall <= 1'b1;
      rx_wait--;
    end else begin
      result_stall <= 1'b0;
    end
  end

  function automatic logic [TEMP_W-1:0] any_temp();
    return TEMP_W'($urandom_range(0, 2047));
  endfunction

  function automatic logic [TEMP_W-1:0] under(input logic [TEMP_W-1:0] t);
    return (t == 0) ? '0 : TEMP_W'($urandom_range(0, t - 1));
  endfunction

  function automatic logic [TEMP_W-1:0] at_or_over(input logic [TEMP_W-1:0] t);
    return TEMP_W'($urandom_range(t, 2047));
  endfunction

  // Present one transaction after a random gap and hold it until taken
  task automatic send_item(input action_t act, input logic [TEMP_W-1:0] nz,
                           input logic [TEMP_W-1:0] br, input logic [TEMP_W-1:0] nz_t,
                           input logic [TEMP_W-1:0] br_t, input logic [MELT_W-1:0] mt);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid     <= 1'b1;
    action         <= act;
    nozzle_reading <= nz;
    barrel_reading <= br;
    nozzle_target  <= nz_t;
    barrel_target  <= br_t;
    melt_ticks     <= mt;
    do @(posedge clk); while (item_stall);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_stray();
    send_item(action_t'($urandom_range(1, 3)), any_temp(), any_temp(), any_temp(),
              any_temp(), MELT_W'($urandom));
  endtask

  // Tick with random ignored fields, now and then preceded by a stray command
  task automatic send_tick(input logic [TEMP_W-1:0] nz, input logic [TEMP_W-1:0] br);
    if ($urandom_range(0, 29) == 0) send_stray();
    send_item(ACT_TICK, nz, br, any_temp(), any_temp(), MELT_W'($urandom));
  endtask

  // Drop valid and wait for every outstanding result
  task automatic settle();
    item_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write all five registers, junk in the unused upper data bits
  task automatic apply_settings(input int unsigned duty, input int unsigned ins,
                                input int unsigned inj, input int unsigned led,
                                input int unsigned warm);
    logic [CFG_IDX_W-1:0]  idx[5];
    int unsigned           vals[5];
    int unsigned           widths[5];
    logic [CFG_DATA_W-1:0] junk;
    idx    = '{CFG_HEATER_DUTY, CFG_INSERT_HOLD, CFG_INJECT_HOLD, CFG_LED_HALF,
               CFG_WARM_THRESH};
    vals   = '{duty, ins, inj, led, warm};
    widths = '{DUTY_W, HOLD_W, HOLD_W, BLINK_W, TEMP_W};
    cur_insert = ins;
    cur_inject = inj;
    cfg_valid <= 1'b1;
    for (int i = 0; i < 5; i++) begin
      junk = CFG_DATA_W'($urandom);
      cfg_index <= idx[i];
      cfg_data  <= (CFG_DATA_W'(vals[i]) & CFG_DATA_W'((1 << widths[i]) - 1)) |
                   (junk & ~CFG_DATA_W'((1 << widths[i]) - 1));
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    // Unmapped index must be ignored
    if ($urandom_range(0, 1) == 1) begin
      cfg_index <= CFG_WARM_THRESH + CFG_IDX_W'($urandom_range(1, 3));
      cfg_data  <= CFG_DATA_W'($urandom);
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // One molding cycle: start, heat until both setpoints, then tick through the holds up to a capped tick budget
  task automatic molding_run();
    logic [TEMP_W-1:0] nt;
    logic [TEMP_W-1:0] bt;
    logic [MELT_W-1:0] mt;
    int unsigned       body;
    nt = any_temp();
    bt = any_temp();
    mt = ($urandom_range(0, 9) == 0) ? MELT_W'($urandom) : MELT_W'($urandom_range(0, 12));
    send_item(ACT_START, any_temp(), any_temp(), nt, bt, mt);
    repeat ($urandom_range(0, 4)) send_tick(under(nt), any_temp());
    send_tick(at_or_over(nt), at_or_over(bt));
    body = cur_insert + cur_inject + mt + 3 + $urandom_range(0, 3);
    if (body > 80) body = 80;
    repeat (body) send_tick(any_temp(), any_temp());
    if ($urandom_range(0, 7) == 0)
      send_item(ACT_CANCEL, any_temp(), any_temp(), any_temp(), any_temp(),
                MELT_W'($urandom));
  endtask

  // Manual heat in standby, ticking until a channel gets hot
  task automatic manual_heat_run();
    logic [TEMP_W-1:0] nt;
    logic [TEMP_W-1:0] bt;
    nt = any_temp();
    bt = any_temp();
    send_item(ACT_HEAT, under(nt), under(bt), nt, bt, MELT_W'($urandom));
    repeat ($urandom_range(0, 4)) send_tick(under(nt), under(bt));
    if ($urandom_range(0, 1) == 1) send_tick(at_or_over(nt), under(bt));
    else send_tick(under(nt), at_or_over(bt));
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Directed opening with reset settings
    send_item(ACT_TICK, '0, '0, '0, '0, '0);
    send_item(ACT_TICK, '1, '1, '1, '1, '1);
    send_item(ACT_HEAT, '0, '0, '1, '1, '0);
    send_item(ACT_TICK, '0, '0, '0, '0, '0);
    send_item(ACT_TICK, '1, '0, '0, '0, '0);
    send_item(ACT_HEAT, '0, '0, '0, '0, '0);
    send_item(ACT_CANCEL, 11'd41, 11'd40, '0, '0, '0);
    send_item(ACT_TICK, 11'd40, 11'd40, '0, '0, '0);
    send_item(ACT_START, '0, '0, 11'd100, 11'd100, '1);
    send_item(ACT_START, '0, '0, 11'd5, 11'd5, '0);
    send_item(ACT_HEAT, '0, '0, 11'd7, 11'd7, '0);
    send_item(ACT_TICK, 11'd99, 11'd100, '0, '0, '0);
    send_item(ACT_TICK, 11'd100, 11'd100, '0, '0, '0);
    send_item(ACT_CANCEL, '0, '0, '0, '0, '0);
    send_item(ACT_START, '0, '0, '0, '0, '0);
    send_item(ACT_TICK, '0, '0, '0, '0, '0);
    send_item(ACT_CANCEL, '0, '0, '0, '0, '0);

    // Zero holds, fastest blink, full duty, top warm threshold
    settle();
    apply_settings(255, 0, 0, 0, 2047);
    send_item(ACT_START, '0, '0, '0, '0, '0);
    repeat (4) send_item(ACT_TICK, '0, '0, '0, '0, '0);
    send_item(ACT_TICK, '1, '1, '0, '0, '0);
    send_item(ACT_HEAT, '0, '0, '1, '1, '0);

    // Random cycles under a series of settings
    for (int p = 0; p < SETTING_ROUNDS; p++) begin
      settle();
      case (p)
        0: apply_settings(0, 65535, 65535, 1023, 0);
        1: apply_settings(255, 0, 0, 1, $urandom_range(0, 2047));
        default: apply_settings($urandom_range(0, 255), $urandom_range(0, 10),
                                $urandom_range(0, 10), $urandom_range(0, 20),
                                $urandom_range(0, 2047));
      endcase
      round_quota = (p == 0) ? 80 : 230;
      round_base  = items_sent;
      while (items_sent - round_base < round_quota) begin
        tx_burst = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 5) == 0) manual_heat_run();
        else molding_run();
      end
      tx_burst = 1'b0;
      send_item(ACT_CANCEL, any_temp(), any_temp(), any_temp(), any_temp(),
                MELT_W'($urandom));
    end

    settle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
